// File: rtl/ksss_pkg.sv
// ----------------------------------------------------------------------------
// ksss_pkg
// Shared types and constants of the k-sorted stream sorter.
// ----------------------------------------------------------------------------
package ksss_pkg;

  localparam int VALUE_W       = 32;
  localparam int K_W           = 4;
  localparam int STORE_DEPTH_D = 16;

  // command a cell carries out
  typedef enum logic [1:0] {
    CELL_HOLD   = 2'd0,
    CELL_SHIFT  = 2'd1,
    CELL_INSERT = 2'd2
  } cell_op_t;

  // broadcast to every cell of the chain
  typedef struct packed {
    cell_op_t                   op;
    logic signed [VALUE_W-1:0]  ins_value;
  } cell_ctrl_t;

  // where a cell sits relative to the fill level
  typedef struct packed {
    logic occ;   // cell holds a live value
    logic tail;  // first free cell
  } cell_pos_t;

  typedef enum logic [1:0] {
    ST_IDLE   = 2'd0,
    ST_INSERT = 2'd1,
    ST_DRAIN  = 2'd2
  } sorter_state_t;

endpackage

// File: rtl/ksss_in_if.sv
// ----------------------------------------------------------------------------
// ksss_in_if
// Input request channel: one stream value and its last mark.
// ----------------------------------------------------------------------------
interface ksss_in_if import ksss_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [VALUE_W-1:0] value;
  logic                      is_last;

  modport source (output valid, output value, output is_last, input ready);
  modport sink   (input valid, input value, input is_last, output ready);
endinterface

// File: rtl/ksss_out_if.sv
// ----------------------------------------------------------------------------
// ksss_out_if
// Output request channel: one sorted value and its end mark.
// ----------------------------------------------------------------------------
interface ksss_out_if import ksss_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [VALUE_W-1:0] sorted_value;
  logic                      end_of_stream;

  modport source (output valid, output sorted_value, output end_of_stream, input ready);
  modport sink   (input valid, input sorted_value, input end_of_stream, output ready);
endinterface

// File: rtl/k_sorted_stream_sorter_unit.sv
// ----------------------------------------------------------------------------
// k_sorted_stream_sorter_unit
// Sorter for a stream whose values are at most k places out of order.
// ----------------------------------------------------------------------------
// stream_in takes a signed value and a last mark; stream_out gives values in
// ascending order, end_of_stream set on the final one. cfg_wr_en/cfg_wr_data
// write k_distance, the user doing so only while the block is idle; the
// block does not enforce it. The window is min(k+1, depth). The store is a
// chain of cells kept in ascending order. On a request the head is popped
// into the output register when the window is full, then the whole chain
// opens a gap and inserts in parallel. A popped value shows on stream_out in
// the cycle after acceptance. After a last-marked request the chain drains
// one value per cycle unless the receiver stalls. The single output register
// sets the pace: a new request is taken only when that register is free or
// being read, so a stalled receiver holds the input off and nothing is lost.
// Reset empties the store (fill count zero) and clears k_distance; cell
// contents need no clearing since only live cells are ever read.
// ----------------------------------------------------------------------------
module k_sorted_stream_sorter_unit import ksss_pkg::*; #(
  parameter int STORE_DEPTH = STORE_DEPTH_D
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           cfg_wr_en,
  input  logic [K_W-1:0] cfg_wr_data,
  ksss_in_if.sink        stream_in,
  ksss_out_if.source     stream_out
);

  localparam int CW = $clog2(STORE_DEPTH + 1);
  localparam int WW = (CW > K_W + 1) ? CW : K_W + 1;

  sorter_state_t             state, state_next;
  logic [K_W-1:0]            k_distance;
  logic [CW-1:0]             count, count_next;
  logic signed [VALUE_W-1:0] cap_value;
  logic                      cap_last;
  logic                      out_valid, out_valid_next;
  logic signed [VALUE_W-1:0] out_value;
  logic                      out_end, out_end_next;
  logic                      load_out, accept, out_free, pop_need;
  logic [WW-1:0]             win_k, win;
  cell_ctrl_t                ctrl;

  logic                      cell_act [STORE_DEPTH];
  logic signed [VALUE_W-1:0] cell_val [STORE_DEPTH];

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      k_distance <= '0;
    end else if (cfg_wr_en) begin
      k_distance <= cfg_wr_data;
    end
  end

  // window size and pop decision
  assign win_k    = WW'(k_distance) + WW'(1);
  assign win      = (win_k > WW'(STORE_DEPTH)) ? WW'(STORE_DEPTH) : win_k;
  assign pop_need = (WW'(count) >= win);

  assign out_free        = !out_valid || stream_out.ready;
  assign stream_in.ready = (state == ST_IDLE) && out_free;
  assign accept          = stream_in.valid && stream_in.ready;

  // chain of cells
  for (genvar i = 0; i < STORE_DEPTH; i++) begin : g_cell
    cell_pos_t pos;
    assign pos.occ  = (CW'(i) < count);
    assign pos.tail = (CW'(i) == count);
    ksss_cell u_cell (
      .clk         (clk),
      .ctrl        (ctrl),
      .pos         (pos),
      .left_act    ((i == 0) ? 1'b0 : cell_act[(i == 0) ? 0 : i - 1]),
      .left_value  (cell_val[(i == 0) ? 0 : i - 1]),
      .right_value (cell_val[(i == STORE_DEPTH - 1) ? i : i + 1]),
      .act         (cell_act[i]),
      .value       (cell_val[i])
    );
  end

  // next state, cell command and output load
  always_comb begin
    state_next     = state;
    count_next     = count;
    load_out       = 1'b0;
    out_end_next   = 1'b0;
    ctrl.op        = CELL_HOLD;
    ctrl.ins_value = cap_value;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = ST_INSERT;
          if (pop_need) begin
            load_out   = 1'b1;
            ctrl.op    = CELL_SHIFT;
            count_next = count - CW'(1);
          end
        end
      end
      ST_INSERT: begin
        ctrl.op    = CELL_INSERT;
        count_next = count + CW'(1);
        state_next = cap_last ? ST_DRAIN : ST_IDLE;
      end
      ST_DRAIN: begin
        if (out_free) begin
          load_out     = 1'b1;
          out_end_next = (count == CW'(1));
          ctrl.op      = CELL_SHIFT;
          count_next   = count - CW'(1);
          if (count == CW'(1)) begin
            state_next = ST_IDLE;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
    out_valid_next = load_out || (out_valid && !stream_out.ready);
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      out_valid <= out_valid_next;
    end
  end

  // captured request and output register
  always_ff @(posedge clk) begin
    if (accept) begin
      cap_value <= stream_in.value;
      cap_last  <= stream_in.is_last;
    end
    if (load_out) begin
      out_value <= cell_val[0];
      out_end   <= out_end_next;
    end
  end

  assign stream_out.valid         = out_valid;
  assign stream_out.sorted_value  = out_value;
  assign stream_out.end_of_stream = out_end;

  // checks
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(STORE_DEPTH))
    else $error("fill count above store depth");

  a_insert_room: assert property (@(posedge clk) disable iff (rst)
    state == ST_INSERT |-> count < CW'(STORE_DEPTH))
    else $error("insert into full store");

  a_drain_nonempty: assert property (@(posedge clk) disable iff (rst)
    state == ST_DRAIN |-> count != '0)
    else $error("drain of empty store");

  a_end_empty: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_end) |-> (count == '0 && state == ST_IDLE))
    else $error("end of stream sent while values held");

endmodule

// File: rtl/ksss_cell.sv
// ----------------------------------------------------------------------------
// ksss_cell
// One slot of the sorted chain: holds a value, shifts toward the head on a
// pop and opens a gap for a new value on an insert.
// ----------------------------------------------------------------------------
module ksss_cell import ksss_pkg::*; (
  input  logic                      clk,
  input  cell_ctrl_t                ctrl,
  input  cell_pos_t                 pos,
  input  logic                      left_act,
  input  logic signed [VALUE_W-1:0] left_value,
  input  logic signed [VALUE_W-1:0] right_value,
  output logic                      act,
  output logic signed [VALUE_W-1:0] value
);

  // cell moves on insert when new value sorts before it, or it is the first free slot
  assign act = pos.occ ? (ctrl.ins_value < value) : pos.tail;

  // value register
  always_ff @(posedge clk) begin
    case (ctrl.op)
      CELL_SHIFT: value <= right_value;
      CELL_INSERT: begin
        if (act) begin
          value <= left_act ? left_value : ctrl.ins_value;
        end
      end
      default: value <= value;
    endcase
  end

endmodule

// File: tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Checks the k-sorted stream sorter against a behavioral model of the
// min-window store: a directed table, a back-pressure run and random nearly
// sorted streams.
// ----------------------------------------------------------------------------
// Every accepted request is run through a queue model of the store. The
// results it gives are queued and compared field by field with what the
// block emits. k_distance is rewritten between streams, and sometimes in the
// middle of one, once the block has gone quiet.
// ----------------------------------------------------------------------------
module testbench;
  import ksss_pkg::*;

  localparam int ITEM_GOAL      = 420;
  localparam int CALM_TAIL      = 60;
  localparam int SETTLE_CYCLES  = 2 + STORE_DEPTH_D + 6;
  localparam int LONG_HOLD      = 300;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int MAX_STREAM     = 40;
  localparam int MAX_PRINTED    = 50;

  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic                      eos;
  } sorted_t;

  typedef enum logic [1:0] {
    ROW_SEND  = 2'd0,  // request checked against the model
    ROW_CHECK = 2'd1,  // request with its one result written out
    ROW_SET_K = 2'd2   // k_distance write, value holds k
  } row_kind_t;

  typedef struct packed {
    row_kind_t                 kind;
    logic signed [VALUE_W-1:0] value;
    logic                      last;
    logic signed [VALUE_W-1:0] exp_value;
    logic                      exp_eos;
  } row_t;

  localparam int N_ROWS = 19;
  localparam row_t DIRECTED_ROWS [N_ROWS] = '{
    // from reset k is 0: a window of one, each request pushes out the previous
    '{ROW_SEND,  32'sh7fffffff, 1'b0, 32'sd0,        1'b0},
    '{ROW_CHECK, 32'sh80000000, 1'b0, 32'sh7fffffff, 1'b0},
    '{ROW_CHECK, 32'sd0,        1'b0, 32'sh80000000, 1'b0},
    '{ROW_SEND,  -32'sd1,       1'b1, 32'sd0,        1'b0},
    // widest window, short stream with equal values and both extremes
    '{ROW_SET_K, 32'sd15,       1'b0, 32'sd0,        1'b0},
    '{ROW_SEND,  32'sd3,        1'b0, 32'sd0,        1'b0},
    '{ROW_SEND,  -32'sd7,       1'b0, 32'sd0,        1'b0},
    '{ROW_SEND,  32'sd3,        1'b0, 32'sd0,        1'b0},
    '{ROW_SEND,  32'sh7fffffff, 1'b0, 32'sd0,        1'b0},
    '{ROW_SEND,  32'sh80000000, 1'b1, 32'sd0,        1'b0},
    // window shrunk while five values are held
    '{ROW_SEND,  32'sd10,       1'b0, 32'sd0,        1'b0},
    '{ROW_SEND,  32'sd20,       1'b0, 32'sd0,        1'b0},
    '{ROW_SEND,  32'sd30,       1'b0, 32'sd0,        1'b0},
    '{ROW_SEND,  32'sd40,       1'b0, 32'sd0,        1'b0},
    '{ROW_SEND,  32'sd50,       1'b0, 32'sd0,        1'b0},
    '{ROW_SET_K, 32'sd1,        1'b0, 32'sd0,        1'b0},
    '{ROW_CHECK, 32'sd5,        1'b0, 32'sd10,       1'b0},
    '{ROW_SEND,  32'sd60,       1'b1, 32'sd0,        1'b0},
    // stream of a single request
    '{ROW_CHECK, -32'sd1,       1'b1, -32'sd1,       1'b1}
  };

  logic           clk = 1'b0;
  logic           rst;
  logic           cfg_wr_en;
  logic [K_W-1:0] cfg_wr_data;

  ksss_in_if  in_bus ();
  ksss_out_if out_bus ();

  k_sorted_stream_sorter_unit u_top (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .stream_in   (in_bus),
    .stream_out  (out_bus)
  );

  // model state and the results still owed by the block
  logic [K_W-1:0]            k_cur = '0;
  logic signed [VALUE_W-1:0] held_q[$];
  sorted_t                   sorted_q[$];

  int mismatches  = 0;
  int items_sent  = 0;
  int gap_pct     = 0;
  int idle_cycles = 0;
  bit calm        = 1'b0;
  bit hold_on     = 1'b0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  task automatic report_mismatch(input string what, input logic signed [VALUE_W-1:0] want,
                                 input logic signed [VALUE_W-1:0] got);
    mismatches++;
    // keep the log short on a badly broken block
    if (mismatches <= MAX_PRINTED)
      $display("%0t mismatch on %s: expected %0d got %0d", $time, what, want, got);
  endtask

  // one request through the window store, returns how many results it queued
  function automatic int sort_window_step(input logic signed [VALUE_W-1:0] v, input logic last);
    int n;
    int pos;
    int window;
    logic signed [VALUE_W-1:0] head;
    n = 0;
    window = (int'(k_cur) + 1 > STORE_DEPTH_D) ? STORE_DEPTH_D : int'(k_cur) + 1;
    // full window: the smallest held value leaves first
    if (held_q.size() >= window && held_q.size() > 0) begin
      head = held_q.pop_front();
      sorted_q.push_back(sorted_t'{head, 1'b0});
      n++;
    end
    // insert keeping ascending order
    pos = held_q.size();
    while (pos > 0 && v < held_q[pos-1]) pos--;
    held_q.insert(pos, v);
    // last request drains the store
    if (last) begin
      while (held_q.size() > 0) begin
        head = held_q.pop_front();
        sorted_q.push_back(sorted_t'{head, held_q.size() == 0});
        n++;
      end
    end
    return n;
  endfunction

  // offer one request, wait for acceptance, then queue what it should give
  task automatic send_request(input logic signed [VALUE_W-1:0] v, input logic last,
                              input logic typed, input logic signed [VALUE_W-1:0] exp_v,
                              input logic exp_e);
    int n;
    if (!calm && $urandom_range(0, 99) < gap_pct)
      repeat ($urandom_range(1, 7)) @(negedge clk) in_bus.valid <= 1'b0;
    @(negedge clk);
    in_bus.valid   <= 1'b1;
    in_bus.value   <= v;
    in_bus.is_last <= last;
    do @(posedge clk); while (!in_bus.ready);
    n = sort_window_step(v, last);
    if (typed) begin
      repeat (n) void'(sorted_q.pop_back());
      sorted_q.push_back(sorted_t'{exp_v, exp_e});
    end
    items_sent++;
  endtask

  // k_distance write once every result is out and the block has settled
  task automatic write_window(input logic [K_W-1:0] k);
    @(negedge clk) in_bus.valid <= 1'b0;
    while (sorted_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= k;
    @(negedge clk) cfg_wr_en <= 1'b0;
    k_cur = k;
  endtask

  // stream: ascending ramp or random noise, scrambled inside window-sized blocks
  task automatic run_random_stream();
    logic signed [VALUE_W-1:0] vals[$];
    logic signed [VALUE_W-1:0] t;
    logic [K_W-1:0]            k_new;
    int len, w, b, j, r, i, step, base, split, blk;
    bit noise;
    if ($urandom_range(0, 3) == 0)
      k_new = $urandom_range(0, 1) ? 4'd15 : 4'd0;
    else
      k_new = K_W'($urandom_range(0, 15));
    write_window(k_new);
    w = int'(k_new) + 1;
    len = ($urandom_range(0, 4) == 0) ? $urandom_range(1, w) : $urandom_range(w + 1, MAX_STREAM);
    noise = ($urandom_range(0, 5) == 0);
    base = $urandom;
    step = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 100000);
    for (i = 0; i < len; i++)
      vals.push_back(noise ? $urandom : base + i * step);
    for (b = 0; b < len; b += w) begin
      blk = (len - b < w) ? len - b : w;
      for (j = blk - 1; j > 0; j--) begin
        r = $urandom_range(0, j);
        t = vals[b+j];
        vals[b+j] = vals[b+r];
        vals[b+r] = t;
      end
    end
    // sometimes k changes while values are held
    split = ($urandom_range(0, 5) == 0 && len > 2) ? $urandom_range(1, len - 1) : -1;
    case ($urandom_range(0, 2))
      0: gap_pct = 0;
      1: gap_pct = 25;
      default: gap_pct = 50;
    endcase
    for (i = 0; i < len; i++) begin
      if (i == split) write_window(K_W'($urandom_range(0, 15)));
      send_request(vals[i], i == len - 1, 1'b0, '0, 1'b0);
    end
  endtask

  // compare each accepted result with the oldest owed one
  always @(posedge clk) begin : check_results
    sorted_t want;
    if (!rst && out_bus.valid && out_bus.ready) begin
      if (sorted_q.size() == 0) begin
        report_mismatch("unexpected result", '0, out_bus.sorted_value);
      end else begin
        want = sorted_q.pop_front();
        if (out_bus.sorted_value !== want.value)
          report_mismatch("sorted_value", want.value, out_bus.sorted_value);
        if (out_bus.end_of_stream !== want.eos)
          report_mismatch("end_of_stream", want.eos, out_bus.end_of_stream);
      end
    end
  end

  // cycles with no request moving on either side
  always @(posedge clk) begin
    if (rst || (in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("testbench: FAIL");
      $finish;
    end
  end

  // receiver: random stall bursts, one long hold-off on request
  initial begin : receiver
    out_bus.ready = 1'b0;
    forever begin
      if (hold_on) begin
        repeat (LONG_HOLD) @(negedge clk) out_bus.ready <= 1'b0;
        hold_on = 1'b0;
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        repeat ($urandom_range(1, 7)) @(negedge clk) out_bus.ready <= 1'b0;
      end else begin
        repeat ($urandom_range(1, 12)) @(negedge clk) out_bus.ready <= 1'b1;
      end
    end
  end

  // sender and run control
  initial begin : sender
    int i;
    rst            = 1'b1;
    cfg_wr_en      = 1'b0;
    cfg_wr_data    = '0;
    in_bus.valid   = 1'b0;
    in_bus.value   = '0;
    in_bus.is_last = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    // directed table
    gap_pct = 30;
    for (i = 0; i < N_ROWS; i++) begin
      case (DIRECTED_ROWS[i].kind)
        ROW_SET_K: write_window(DIRECTED_ROWS[i].value[K_W-1:0]);
        default: send_request(DIRECTED_ROWS[i].value, DIRECTED_ROWS[i].last,
                              DIRECTED_ROWS[i].kind == ROW_CHECK,
                              DIRECTED_ROWS[i].exp_value, DIRECTED_ROWS[i].exp_eos);
      endcase
    end

    // receiver holds off while the sender keeps offering, so the input stalls
    write_window(4'd15);
    gap_pct = 0;
    hold_on = 1'b1;
    for (i = 0; i < MAX_STREAM; i++)
      send_request($urandom, i == MAX_STREAM - 1, 1'b0, '0, 1'b0);

    // random streams, no idling near the end
    while (items_sent < ITEM_GOAL) begin
      calm = (items_sent >= ITEM_GOAL - CALM_TAIL);
      run_random_stream();
    end

    @(negedge clk) in_bus.valid <= 1'b0;
    while (sorted_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("testbench: PASS");
    else
      $display("testbench: FAIL");
    $finish;
  end

endmodule
